// ----- rtl/core/ebc_pkg.sv -----
// Shared types, opcode constants and helpers for the eight-bit register CPU core.
`default_nettype none

package ebc_pkg;

    // Request operations.
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Instruction opcodes.
    localparam logic [7:0] OPC_NOP  = 8'd0;
    localparam logic [7:0] OPC_LDA  = 8'd1;
    localparam logic [7:0] OPC_LDB  = 8'd2;
    localparam logic [7:0] OPC_LDI  = 8'd3;
    localparam logic [7:0] OPC_INC  = 8'd4;
    localparam logic [7:0] OPC_DEC  = 8'd5;
    localparam logic [7:0] OPC_ADD  = 8'd6;
    localparam logic [7:0] OPC_SUB  = 8'd7;
    localparam logic [7:0] OPC_MUL  = 8'd8;
    localparam logic [7:0] OPC_STA  = 8'd9;
    localparam logic [7:0] OPC_STB  = 8'd10;
    localparam logic [7:0] OPC_MOV  = 8'd11;
    localparam logic [7:0] OPC_CMP  = 8'd12;
    localparam logic [7:0] OPC_JMP  = 8'd13;
    localparam logic [7:0] OPC_JZ   = 8'd14;
    localparam logic [7:0] OPC_JNZ  = 8'd15;
    localparam logic [7:0] OPC_JC   = 8'd16;
    localparam logic [7:0] OPC_JNC  = 8'd17;
    localparam logic [7:0] OPC_JE   = 8'd18;
    localparam logic [7:0] OPC_JNE  = 8'd19;
    localparam logic [7:0] OPC_JL   = 8'd20;
    localparam logic [7:0] OPC_JG   = 8'd21;
    localparam logic [7:0] OPC_JB   = 8'd22;
    localparam logic [7:0] OPC_JA   = 8'd23;
    localparam logic [7:0] OPC_AND  = 8'd24;
    localparam logic [7:0] OPC_OR   = 8'd25;
    localparam logic [7:0] OPC_XOR  = 8'd26;
    localparam logic [7:0] OPC_NOT  = 8'd27;
    localparam logic [7:0] OPC_PUSH = 8'd28;
    localparam logic [7:0] OPC_POP  = 8'd29;
    localparam logic [7:0] OPC_CALL = 8'd30;
    localparam logic [7:0] OPC_RET  = 8'd31;

    // Flag bit positions.
    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_O = 3;

    // Byte constants used by the flag logic.
    localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
    localparam logic [7:0] BYTE_MAX_POS = 8'h7F;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mem_addr;
        logic [7:0] mem_data;
    } ebc_req_t;

    typedef struct packed {
        logic [15:0] prog_counter;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [3:0]  flag_bits;
        logic        is_halted;
        logic        is_fault;
        logic [7:0]  read_byte;
    } ebc_rsp_t;

    // Number of operand bytes that follow an opcode.
    function automatic logic [1:0] operand_bytes(input logic [7:0] opc);
        logic [1:0] n;
        n = 2'd0;
        if (opc == OPC_LDI || opc == OPC_NOT || opc == OPC_PUSH || opc == OPC_POP) begin
            n = 2'd1;
        end else if ((opc >= OPC_LDA && opc <= OPC_LDB) ||
                     (opc >= OPC_ADD && opc <= OPC_JA) ||
                     (opc >= OPC_AND && opc <= OPC_XOR) || opc == OPC_CALL) begin
            n = 2'd2;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ebc_req_if.sv -----
// Request channel interface carrying one command to the core.
`default_nettype none

interface ebc_req_if
    import ebc_pkg::*;
();
    logic     valid;
    logic     ready;
    ebc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ebc_rsp_if.sv -----
// Response channel interface carrying the architectural state after each request.
`default_nettype none

interface ebc_rsp_if
    import ebc_pkg::*;
();
    logic     valid;
    logic     ready;
    ebc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/eight_bit_register_cpu_core.sv -----
// Eight-bit register CPU core: sequencer around a single-port program and data memory.
// An instruction passes the accept in S_IDLE, the opcode fetch in S_F0 and S_F1, any operand
// fetch in S_F2 and, for a second operand byte, S_F3, execute in S_EX, and after execute S_LD
// for a load or POP, S_CALL2 for CALL, or S_RET2 then S_RET3 for RET. A memory read passes
// S_RD; a write, op 3 or a halted execute is answered from S_IDLE. A new request is taken only
// in S_IDLE, when the previous response is taken or while the response register is empty.
// Reset clears registers, flags, PC, halt and fault, and sets SP to MEM_DEPTH - 1.
// Memory contents are not reset; reading a byte never written returns an undefined value.
`default_nettype none

module eight_bit_register_cpu_core
    import ebc_pkg::*;
#(
    parameter int MEM_DEPTH = 256,
    parameter int NUM_REGS  = 4
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ebc_req_if.sink    cmd,
    ebc_rsp_if.source  rsp
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int RIW = $clog2(NUM_REGS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RD    = 11'b000_0000_0010,
        S_F0    = 11'b000_0000_0100,
        S_F1    = 11'b000_0000_1000,
        S_F2    = 11'b000_0001_0000,
        S_F3    = 11'b000_0010_0000,
        S_EX    = 11'b000_0100_0000,
        S_LD    = 11'b000_1000_0000,
        S_CALL2 = 11'b001_0000_0000,
        S_RET2  = 11'b010_0000_0000,
        S_RET3  = 11'b100_0000_0000
    } state_t;

    state_t       state_reg, state_next;
    logic [7:0]   regs_reg [NUM_REGS];
    logic [7:0]   regs_next [NUM_REGS];
    logic [15:0]  pc_reg, pc_next;
    logic [15:0]  sp_reg, sp_next;
    logic [3:0]   flag_reg, flag_next;
    logic         halt_reg, halt_next;
    logic         fault_reg, fault_next;
    logic [7:0]   opc_reg, opc_next;
    logic [7:0]   b1_reg, b1_next;
    logic [7:0]   b2_reg, b2_next;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   rb_reg, rb_next;

    logic [7:0]   mem [MEM_DEPTH];
    logic [7:0]   rd_reg;
    logic [AW-1:0] mem_addr_c;
    logic         mem_we;
    logic [7:0]   mem_wd;

    logic         accept;
    logic         finish;

    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    // Single-port memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr_c] <= mem_wd;
        end
        rd_reg <= mem[mem_addr_c];
    end

    // Sequencer and datapath.
    always_comb
    begin
        logic [15:0] addr16;
        logic [RIW-1:0] ri, si;
        logic        bad_r, bad_s;
        logic [7:0]  x, y, res;
        logic [8:0]  sum9;
        logic [15:0] prod;
        logic        take;
        logic        zf, sf, cf, of;

        state_next  = state_reg;
        regs_next   = regs_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        flag_next   = flag_reg;
        halt_next   = halt_reg;
        fault_next  = fault_reg;
        opc_next    = opc_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        rb_next     = rb_reg;
        finish      = 1'b0;
        mem_we      = 1'b0;
        mem_wd      = cmd.data.mem_data;
        mem_addr_c  = AW'(cmd.data.mem_addr);

        addr16 = {b1_reg, b2_reg};
        ri     = b1_reg[RIW-1:0];
        si     = b2_reg[RIW-1:0];
        bad_r  = ({1'b0, b1_reg} >= 9'(NUM_REGS));
        bad_s  = ({1'b0, b2_reg} >= 9'(NUM_REGS));
        x      = regs_reg[ri];
        y      = regs_reg[si];
        res    = 8'd0;
        sum9   = 9'd0;
        prod   = 16'd0;
        take   = 1'b0;
        zf     = flag_reg[FLAG_Z];
        sf     = flag_reg[FLAG_S];
        cf     = flag_reg[FLAG_C];
        of     = flag_reg[FLAG_O];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.data.op == OP_WRITE)
                    begin
                        mem_we  = 1'b1;
                        rb_next = 8'd0;
                        finish  = 1'b1;
                    end
                    else if (cmd.data.op == OP_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if (cmd.data.op == OP_EXEC && !halt_reg)
                    begin
                        state_next = S_F0;
                    end
                    else
                    begin
                        rb_next = 8'd0;
                        finish  = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                rb_next    = rd_reg;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_F0:
            begin
                mem_addr_c = pc_reg[AW-1:0];
                pc_next    = pc_reg + 16'd1;
                state_next = S_F1;
            end
            S_F1:
            begin
                opc_next = rd_reg;
                if (operand_bytes(rd_reg) != 2'd0)
                begin
                    mem_addr_c = pc_reg[AW-1:0];
                    pc_next    = pc_reg + 16'd1;
                    state_next = S_F2;
                end
                else
                begin
                    state_next = S_EX;
                end
            end
            S_F2:
            begin
                b1_next = rd_reg;
                if (operand_bytes(opc_reg) == 2'd2)
                begin
                    mem_addr_c = pc_reg[AW-1:0];
                    pc_next    = pc_reg + 16'd1;
                    state_next = S_F3;
                end
                else
                begin
                    state_next = S_EX;
                end
            end
            S_F3:
            begin
                b2_next    = rd_reg;
                state_next = S_EX;
            end
            S_EX:
            begin
                rb_next    = 8'd0;
                finish     = 1'b1;
                state_next = S_IDLE;
                priority case (opc_reg)
                    OPC_NOP: ;
                    OPC_LDA, OPC_LDB:
                    begin
                        mem_addr_c = addr16[AW-1:0];
                        finish     = 1'b0;
                        state_next = S_LD;
                    end
                    OPC_LDI:
                    begin
                        regs_next[0]      = b1_reg;
                        flag_next[FLAG_Z] = (b1_reg == 8'd0);
                    end
                    OPC_INC, OPC_DEC:
                    begin
                        res = (opc_reg == OPC_INC) ? regs_reg[0] + 8'd1 : regs_reg[0] - 8'd1;
                        flag_next[FLAG_Z] = (res == 8'd0);
                        flag_next[FLAG_S] = res[7];
                        flag_next[FLAG_O] = (opc_reg == OPC_INC) ?
                                            (regs_reg[0] == BYTE_MAX_POS) :
                                            (regs_reg[0] == BYTE_MIN_NEG);
                        regs_next[0] = res;
                    end
                    OPC_ADD, OPC_SUB, OPC_MUL, OPC_MOV, OPC_CMP,
                    OPC_AND, OPC_OR, OPC_XOR:
                    begin
                        if (bad_r || bad_s)
                        begin
                            fault_next = 1'b1;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            priority case (opc_reg)
                                OPC_ADD:
                                begin
                                    sum9 = {1'b0, x} + {1'b0, y};
                                    res  = sum9[7:0];
                                    flag_next[FLAG_C] = sum9[8];
                                    flag_next[FLAG_O] = ((x ^ res) & (y ^ res) & BYTE_MIN_NEG) != 8'd0;
                                end
                                OPC_SUB, OPC_CMP:
                                begin
                                    res = x - y;
                                    flag_next[FLAG_C] = (x < y);
                                    flag_next[FLAG_O] = ((x ^ y) & (x ^ res) & BYTE_MIN_NEG) != 8'd0;
                                end
                                OPC_MUL:
                                begin
                                    prod = {8'd0, x} * {8'd0, y};
                                    res  = prod[7:0];
                                    flag_next[FLAG_C] = (prod[15:8] != 8'd0);
                                    flag_next[FLAG_O] = 1'b0;
                                end
                                OPC_MOV:
                                begin
                                    res = y;
                                end
                                default:
                                begin
                                    res = (opc_reg == OPC_AND) ? (x & y) :
                                          (opc_reg == OPC_OR) ? (x | y) : (x ^ y);
                                    flag_next[FLAG_C] = 1'b0;
                                    flag_next[FLAG_O] = 1'b0;
                                end
                            endcase
                            if (opc_reg != OPC_MOV)
                            begin
                                flag_next[FLAG_Z] = (res == 8'd0);
                                flag_next[FLAG_S] = res[7];
                            end
                            if (opc_reg != OPC_CMP)
                            begin
                                regs_next[ri] = res;
                            end
                        end
                    end
                    OPC_STA, OPC_STB:
                    begin
                        mem_addr_c = addr16[AW-1:0];
                        mem_we     = 1'b1;
                        mem_wd     = (opc_reg == OPC_STA) ? regs_reg[0] : regs_reg[1];
                    end
                    OPC_JMP, OPC_JZ, OPC_JNZ, OPC_JC, OPC_JNC, OPC_JE, OPC_JNE,
                    OPC_JL, OPC_JG, OPC_JB, OPC_JA:
                    begin
                        priority case (opc_reg)
                            OPC_JMP:          take = 1'b1;
                            OPC_JZ, OPC_JE:   take = zf;
                            OPC_JNZ, OPC_JNE: take = !zf;
                            OPC_JC, OPC_JB:   take = cf;
                            OPC_JNC:          take = !cf;
                            OPC_JL:           take = (sf != of);
                            OPC_JG:           take = !zf && (sf == of);
                            default:          take = !cf && !zf;
                        endcase
                        if (take)
                        begin
                            pc_next = addr16;
                        end
                    end
                    OPC_NOT:
                    begin
                        if (bad_r)
                        begin
                            fault_next = 1'b1;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            res = x ^ BYTE_ONES;
                            flag_next[FLAG_Z] = (res == 8'd0);
                            flag_next[FLAG_S] = res[7];
                            flag_next[FLAG_C] = 1'b0;
                            flag_next[FLAG_O] = 1'b0;
                            regs_next[ri] = res;
                        end
                    end
                    OPC_PUSH:
                    begin
                        if (bad_r)
                        begin
                            fault_next = 1'b1;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            sp_next    = sp_reg - 16'd1;
                            mem_addr_c = sp_next[AW-1:0];
                            mem_we     = 1'b1;
                            mem_wd     = x;
                        end
                    end
                    OPC_POP:
                    begin
                        if (bad_r)
                        begin
                            fault_next = 1'b1;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            mem_addr_c = sp_reg[AW-1:0];
                            sp_next    = sp_reg + 16'd1;
                            finish     = 1'b0;
                            state_next = S_LD;
                        end
                    end
                    OPC_CALL:
                    begin
                        sp_next    = sp_reg - 16'd1;
                        mem_addr_c = sp_next[AW-1:0];
                        mem_we     = 1'b1;
                        mem_wd     = pc_reg[7:0];
                        finish     = 1'b0;
                        state_next = S_CALL2;
                    end
                    OPC_RET:
                    begin
                        mem_addr_c = sp_reg[AW-1:0];
                        sp_next    = sp_reg + 16'd1;
                        finish     = 1'b0;
                        state_next = S_RET2;
                    end
                    default:
                    begin
                        halt_next = 1'b1;
                    end
                endcase
            end
            S_LD:
            begin
                rb_next    = 8'd0;
                finish     = 1'b1;
                state_next = S_IDLE;
                priority case (opc_reg)
                    OPC_LDA:
                    begin
                        regs_next[0]      = rd_reg;
                        flag_next[FLAG_Z] = (rd_reg == 8'd0);
                    end
                    OPC_LDB:
                    begin
                        regs_next[1] = rd_reg;
                    end
                    default:
                    begin
                        regs_next[ri] = rd_reg;
                    end
                endcase
            end
            S_CALL2:
            begin
                sp_next    = sp_reg - 16'd1;
                mem_addr_c = sp_next[AW-1:0];
                mem_we     = 1'b1;
                mem_wd     = pc_reg[15:8];
                pc_next    = addr16;
                rb_next    = 8'd0;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_RET2:
            begin
                b1_next    = rd_reg;
                mem_addr_c = sp_reg[AW-1:0];
                sp_next    = sp_reg + 16'd1;
                state_next = S_RET3;
            end
            S_RET3:
            begin
                pc_next    = {b1_reg, rd_reg};
                rb_next    = 8'd0;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = finish ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
            pc_reg        <= 16'd0;
            sp_reg        <= 16'(MEM_DEPTH - 1);
            flag_reg      <= 4'd0;
            halt_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            regs_reg      <= regs_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            flag_reg      <= flag_next;
            halt_reg      <= halt_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Instruction bytes and read data hold no control meaning.
    always_ff @(posedge clk)
    begin
        opc_reg <= opc_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        rb_reg  <= rb_next;
    end

    // Response reflects the architectural state after the request.
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = '{prog_counter: pc_reg, reg_a: regs_reg[0], reg_b: regs_reg[1],
                         flag_bits: flag_reg, is_halted: halt_reg, is_fault: fault_reg,
                         read_byte: rb_reg};

    // A request is never taken while an untaken response would be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> (!out_valid_reg || rsp.ready))
        else $error("request taken over a pending response");

    // A fault always comes with a halt.
    assert property (@(posedge clk) disable iff (!rst_n) fault_reg |-> halt_reg)
        else $error("fault without halt");

    // Only reset clears halt.
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(halt_reg))
        else $error("halt cleared without reset");

    // A halted core leaves the program counter alone on execute requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halt_reg && cmd.data.op == OP_EXEC) |=> $stable(pc_reg))
        else $error("program counter moved while halted");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the eight-bit register CPU core with a built-in predictor.
`default_nettype none

module testbench;
    import ebc_pkg::*;

    localparam int          NREGS      = 4;
    localparam int          MEMSZ      = 256;
    localparam int          RAND_ITEMS = 1670;
    localparam int          CYCLE_CAP  = 300000;
    localparam int          HOLD_LEN   = 300;
    localparam int          IDLE_PCT   = 29;
    localparam logic [7:0]  OPC_HLT    = 8'd32;

    logic clk;
    logic rst_n;

    ebc_req_if cmd_if ();
    ebc_rsp_if rsp_if ();

    eight_bit_register_cpu_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Architectural state tracked by the predictor.
    logic [7:0]  cpu_regs [NREGS];
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;
    logic [3:0]  cpu_flags;
    logic        cpu_halted;
    logic        cpu_fault;
    logic [7:0]  cpu_mem [MEMSZ];

    ebc_rsp_t expected_state_q [$];
    bit       failed;
    bit       idle_on;
    bit       hold_trigger;
    int       cycle_count;

    typedef struct {
        ebc_req_t req;
        bit       typed;
        ebc_rsp_t rsp;
    } directed_row_t;

    directed_row_t directed_rows [$];

    // Clock generation.
    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Instruction fetch helpers; addresses wrap to the memory depth.
    function automatic logic [7:0] next_byte();
        logic [7:0] v;
        v = cpu_mem[cpu_pc[7:0]];
        cpu_pc = cpu_pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] next_addr();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = next_byte();
        lo = next_byte();
        return {hi, lo};
    endfunction

    function automatic void set_zs(input logic [7:0] r);
        cpu_flags[FLAG_Z] = (r == 8'd0);
        cpu_flags[FLAG_S] = r[7];
    endfunction

    // An out-of-range register operand faults and halts the core.
    function automatic bit reg_bad(input logic [7:0] idx);
        if (idx >= NREGS) begin
            cpu_fault  = 1'b1;
            cpu_halted = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Executes one instruction on the tracked state.
    function automatic void run_instruction();
        logic [7:0]  opc;
        logic [7:0]  r;
        logic [7:0]  s;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  res;
        logic [8:0]  sum;
        logic [15:0] prod;
        logic [15:0] tgt;
        logic        zf;
        logic        sf;
        logic        cf;
        logic        of;
        if (cpu_halted) begin
            return;
        end
        zf  = cpu_flags[FLAG_Z];
        sf  = cpu_flags[FLAG_S];
        cf  = cpu_flags[FLAG_C];
        of  = cpu_flags[FLAG_O];
        opc = next_byte();
        case (opc)
            OPC_NOP: begin
            end
            OPC_LDA: begin
                tgt = next_addr();
                cpu_regs[0] = cpu_mem[tgt[7:0]];
                cpu_flags[FLAG_Z] = (cpu_regs[0] == 8'd0);
            end
            OPC_LDB: begin
                tgt = next_addr();
                cpu_regs[1] = cpu_mem[tgt[7:0]];
            end
            OPC_LDI: begin
                cpu_regs[0] = next_byte();
                cpu_flags[FLAG_Z] = (cpu_regs[0] == 8'd0);
            end
            OPC_INC: begin
                x = cpu_regs[0];
                res = x + 8'd1;
                set_zs(res);
                cpu_flags[FLAG_O] = (x == BYTE_MAX_POS);
                cpu_regs[0] = res;
            end
            OPC_DEC: begin
                x = cpu_regs[0];
                res = x - 8'd1;
                set_zs(res);
                cpu_flags[FLAG_O] = (x == BYTE_MIN_NEG);
                cpu_regs[0] = res;
            end
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_MOV, OPC_CMP, OPC_AND, OPC_OR, OPC_XOR: begin
                r = next_byte();
                s = next_byte();
                if (!(reg_bad(r) || reg_bad(s))) begin
                    x = cpu_regs[r[1:0]];
                    y = cpu_regs[s[1:0]];
                    case (opc)
                        OPC_ADD: begin
                            sum = {1'b0, x} + {1'b0, y};
                            res = sum[7:0];
                            set_zs(res);
                            cpu_flags[FLAG_C] = sum[8];
                            cpu_flags[FLAG_O] = ((x ^ res) & (y ^ res) & BYTE_MIN_NEG) != 8'd0;
                            cpu_regs[r[1:0]] = res;
                        end
                        OPC_SUB, OPC_CMP: begin
                            res = x - y;
                            set_zs(res);
                            cpu_flags[FLAG_C] = (x < y);
                            cpu_flags[FLAG_O] = ((x ^ y) & (x ^ res) & BYTE_MIN_NEG) != 8'd0;
                            if (opc == OPC_SUB) begin
                                cpu_regs[r[1:0]] = res;
                            end
                        end
                        OPC_MUL: begin
                            prod = {8'd0, x} * {8'd0, y};
                            res = prod[7:0];
                            set_zs(res);
                            cpu_flags[FLAG_C] = (prod[15:8] != 8'd0);
                            cpu_flags[FLAG_O] = 1'b0;
                            cpu_regs[r[1:0]] = res;
                        end
                        OPC_MOV: begin
                            cpu_regs[r[1:0]] = y;
                        end
                        default: begin
                            if (opc == OPC_AND) begin
                                res = x & y;
                            end else if (opc == OPC_OR) begin
                                res = x | y;
                            end else begin
                                res = x ^ y;
                            end
                            set_zs(res);
                            cpu_flags[FLAG_C] = 1'b0;
                            cpu_flags[FLAG_O] = 1'b0;
                            cpu_regs[r[1:0]] = res;
                        end
                    endcase
                end
            end
            OPC_STA: begin
                tgt = next_addr();
                cpu_mem[tgt[7:0]] = cpu_regs[0];
            end
            OPC_STB: begin
                tgt = next_addr();
                cpu_mem[tgt[7:0]] = cpu_regs[1];
            end
            OPC_JMP, OPC_JZ, OPC_JE, OPC_JNZ, OPC_JNE, OPC_JC, OPC_JB, OPC_JNC,
            OPC_JL, OPC_JG, OPC_JA: begin
                tgt = next_addr();
                case (opc)
                    OPC_JMP:         cpu_pc = tgt;
                    OPC_JZ, OPC_JE:  if (zf) cpu_pc = tgt;
                    OPC_JNZ, OPC_JNE: if (!zf) cpu_pc = tgt;
                    OPC_JC, OPC_JB:  if (cf) cpu_pc = tgt;
                    OPC_JNC:         if (!cf) cpu_pc = tgt;
                    OPC_JL:          if (sf != of) cpu_pc = tgt;
                    OPC_JG:          if (!zf && sf == of) cpu_pc = tgt;
                    default:         if (!cf && !zf) cpu_pc = tgt;
                endcase
            end
            OPC_NOT: begin
                r = next_byte();
                if (!reg_bad(r)) begin
                    res = ~cpu_regs[r[1:0]];
                    set_zs(res);
                    cpu_flags[FLAG_C] = 1'b0;
                    cpu_flags[FLAG_O] = 1'b0;
                    cpu_regs[r[1:0]] = res;
                end
            end
            OPC_PUSH: begin
                r = next_byte();
                if (!reg_bad(r)) begin
                    cpu_sp = cpu_sp - 16'd1;
                    cpu_mem[cpu_sp[7:0]] = cpu_regs[r[1:0]];
                end
            end
            OPC_POP: begin
                r = next_byte();
                if (!reg_bad(r)) begin
                    cpu_regs[r[1:0]] = cpu_mem[cpu_sp[7:0]];
                    cpu_sp = cpu_sp + 16'd1;
                end
            end
            OPC_CALL: begin
                tgt = next_addr();
                cpu_sp = cpu_sp - 16'd1;
                cpu_mem[cpu_sp[7:0]] = cpu_pc[7:0];
                cpu_sp = cpu_sp - 16'd1;
                cpu_mem[cpu_sp[7:0]] = cpu_pc[15:8];
                cpu_pc = tgt;
            end
            OPC_RET: begin
                tgt[15:8] = cpu_mem[cpu_sp[7:0]];
                cpu_sp = cpu_sp + 16'd1;
                tgt[7:0] = cpu_mem[cpu_sp[7:0]];
                cpu_sp = cpu_sp + 16'd1;
                cpu_pc = tgt;
            end
            default: begin
                cpu_halted = 1'b1;
            end
        endcase
    endfunction

    // Applies one request to the tracked state and returns the expected response.
    function automatic ebc_rsp_t model_request(input ebc_req_t req);
        ebc_rsp_t o;
        o.read_byte = 8'd0;
        if (req.op == OP_EXEC) begin
            run_instruction();
        end else if (req.op == OP_WRITE) begin
            cpu_mem[req.mem_addr] = req.mem_data;
        end else if (req.op == OP_READ) begin
            o.read_byte = cpu_mem[req.mem_addr];
        end
        o.prog_counter = cpu_pc;
        o.reg_a        = cpu_regs[0];
        o.reg_b        = cpu_regs[1];
        o.flag_bits    = cpu_flags;
        o.is_halted    = cpu_halted;
        o.is_fault     = cpu_fault;
        return o;
    endfunction

    // True when the instruction at PC neither halts nor names a bad register.
    function automatic bit runs_clean();
        logic [7:0] opc;
        logic [7:0] op1;
        logic [7:0] op2;
        opc = cpu_mem[cpu_pc[7:0]];
        op1 = cpu_mem[cpu_pc[7:0] + 8'd1];
        op2 = cpu_mem[cpu_pc[7:0] + 8'd2];
        if (opc > OPC_RET) begin
            return 1'b0;
        end
        case (opc)
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_MOV, OPC_CMP, OPC_AND, OPC_OR, OPC_XOR:
                return (op1 < NREGS) && (op2 < NREGS);
            OPC_NOT, OPC_PUSH, OPC_POP:
                return op1 < NREGS;
            default:
                return 1'b1;
        endcase
    endfunction

    // Drives one request, waits for acceptance and records its expected response.
    task automatic send_req(input ebc_req_t req, input bit typed, input ebc_rsp_t typed_rsp);
        ebc_rsp_t predicted;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= req;
        do begin
            @(posedge clk);
        end while (!cmd_if.ready);
        predicted = model_request(req);
        expected_state_q.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [1:0] op, input logic [7:0] addr,
                              input logic [7:0] data);
        send_req({op, addr, data}, 1'b0, '0);
    endtask

    // Writes one well-formed instruction with random content at PC.
    task automatic plant_instruction(input logic [7:0] opc);
        logic [7:0] base;
        int         nops;
        int         i;
        logic [7:0] b;
        base = cpu_pc[7:0];
        nops = operand_bytes(opc);
        send_plain(OP_WRITE, base, opc);
        for (i = 1; i <= nops; i++) begin
            case (opc)
                OPC_ADD, OPC_SUB, OPC_MUL, OPC_MOV, OPC_CMP, OPC_AND, OPC_OR, OPC_XOR,
                OPC_NOT, OPC_PUSH, OPC_POP:
                    b = 8'($urandom_range(0, NREGS - 1));
                default:
                    b = 8'($urandom_range(0, 255));
            endcase
            send_plain(OP_WRITE, base + 8'(i), b);
        end
    endtask

    // Response side: random back-pressure plus one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_trigger) begin
                hold_left = HOLD_LEN;
                hold_trigger = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Response checker.
    always @(posedge clk) begin
        ebc_rsp_t want;
        ebc_rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (expected_state_q.size() == 0) begin
                $error("response with no request outstanding: %h", got);
                failed = 1'b1;
            end else begin
                want = expected_state_q.pop_front();
                if (got.prog_counter !== want.prog_counter) begin
                    $error("prog_counter expected %h got %h", want.prog_counter,
                           got.prog_counter);
                    failed = 1'b1;
                end
                if (got.reg_a !== want.reg_a) begin
                    $error("reg_a expected %h got %h", want.reg_a, got.reg_a);
                    failed = 1'b1;
                end
                if (got.reg_b !== want.reg_b) begin
                    $error("reg_b expected %h got %h", want.reg_b, got.reg_b);
                    failed = 1'b1;
                end
                if (got.flag_bits !== want.flag_bits) begin
                    $error("flag_bits expected %h got %h", want.flag_bits, got.flag_bits);
                    failed = 1'b1;
                end
                if (got.is_halted !== want.is_halted) begin
                    $error("is_halted expected %b got %b", want.is_halted, got.is_halted);
                    failed = 1'b1;
                end
                if (got.is_fault !== want.is_fault) begin
                    $error("is_fault expected %b got %b", want.is_fault, got.is_fault);
                    failed = 1'b1;
                end
                if (got.read_byte !== want.read_byte) begin
                    $error("read_byte expected %h got %h", want.read_byte, got.read_byte);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("eight_bit_register_cpu_core verification failed");
        $finish;
    end

    // Stimulus.
    initial begin
        directed_row_t row;
        int            sent;
        int            p;
        int            i;
        int            halt_kind;
        logic [7:0]    opc;

        failed       = 1'b0;
        idle_on      = 1'b1;
        hold_trigger = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        rst_n        = 1'b0;
        cpu_regs     = '{default: 8'd0};
        cpu_pc       = 16'd0;
        cpu_sp       = 16'(MEMSZ - 1);
        cpu_flags    = 4'd0;
        cpu_halted   = 1'b0;
        cpu_fault    = 1'b0;
        for (i = 0; i < MEMSZ; i++) begin
            cpu_mem[i] = 8'd0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Load the whole memory so that no unwritten byte is ever read.
        for (i = 0; i < MEMSZ; i++) begin
            send_plain(OP_WRITE, 8'(i), 8'(i));
        end

        // Directed rows: reset state, INC/DEC overflow edges, MUL to zero, unused op.
        directed_rows.push_back('{{OP_READ, 8'hFF, 8'h00}, 1'b1,
                                  {16'h0000, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0, 8'hFF}});
        directed_rows.push_back('{{OP_WRITE, 8'h00, OPC_LDI}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h01, BYTE_MAX_POS}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h02, OPC_INC}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h03, OPC_DEC}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h04, OPC_MUL}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h05, 8'h00}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'h06, 8'h01}, 1'b0, '0});
        directed_rows.push_back('{{OP_EXEC, 8'h00, 8'h00}, 1'b1,
                                  {16'h0002, 8'h7F, 8'h00, 4'h0, 1'b0, 1'b0, 8'h00}});
        directed_rows.push_back('{{OP_EXEC, 8'h00, 8'h00}, 1'b1,
                                  {16'h0003, 8'h80, 8'h00, 4'hA, 1'b0, 1'b0, 8'h00}});
        directed_rows.push_back('{{OP_EXEC, 8'h00, 8'h00}, 1'b1,
                                  {16'h0004, 8'h7F, 8'h00, 4'h8, 1'b0, 1'b0, 8'h00}});
        directed_rows.push_back('{{OP_EXEC, 8'h00, 8'h00}, 1'b0, '0});
        directed_rows.push_back('{{2'd3, 8'hFF, 8'hFF}, 1'b0, '0});
        directed_rows.push_back('{{OP_READ, 8'h00, 8'h00}, 1'b0, '0});
        directed_rows.push_back('{{OP_WRITE, 8'hFF, 8'h00}, 1'b0, '0});
        directed_rows.push_back('{{OP_READ, 8'hFF, 8'h00}, 1'b1,
                                  {16'h0007, 8'h00, 8'h00, 4'h1, 1'b0, 1'b0, 8'h00}});
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_req(row.req, row.typed, row.rsp);
        end

        // Random programs: mostly well-formed instructions planted at PC, some noise.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent == 200) begin
                hold_trigger = 1'b1;
            end
            idle_on = !(sent >= 700 && sent < 1000);
            p = $urandom_range(0, 99);
            if (p < 8) begin
                send_plain(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
                sent++;
            end else if (p < 50 && runs_clean()) begin
                send_plain(OP_EXEC, 8'($urandom), 8'($urandom));
                sent++;
            end else begin
                opc = 8'($urandom_range(0, OPC_RET));
                plant_instruction(opc);
                send_plain(OP_EXEC, 8'($urandom), 8'($urandom));
                sent += 2 + operand_bytes(opc);
            end
        end

        // Stop execution once: plain halt, unknown opcode or bad register operand.
        idle_on = 1'b1;
        halt_kind = $urandom_range(0, 2);
        if (halt_kind == 0) begin
            send_plain(OP_WRITE, cpu_pc[7:0], OPC_HLT);
        end else if (halt_kind == 1) begin
            send_plain(OP_WRITE, cpu_pc[7:0], 8'($urandom_range(OPC_HLT + 1, 255)));
        end else begin
            send_plain(OP_WRITE, cpu_pc[7:0], OPC_ADD);
            send_plain(OP_WRITE, cpu_pc[7:0] + 8'd1, 8'($urandom_range(0, NREGS - 1)));
            send_plain(OP_WRITE, cpu_pc[7:0] + 8'd2, 8'($urandom_range(NREGS, 255)));
        end
        send_plain(OP_EXEC, 8'h00, 8'h00);
        for (i = 0; i < 8; i++) begin
            send_plain(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end
        cmd_if.valid <= 1'b0;

        // Drain and let the core settle.
        while (expected_state_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (!failed) begin
            $display("eight_bit_register_cpu_core verification clean");
        end else begin
            $display("eight_bit_register_cpu_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/ebc_pkg.sv
rtl/core/ebc_req_if.sv
rtl/core/ebc_rsp_if.sv
rtl/core/eight_bit_register_cpu_core.sv
test/testbench.sv
